### design/udpdt_pkg.sv
// Package for the UDP port demux table: command and status codes,
// the request token that walks the cell row, and the bind write bus.
// No dependencies.
package udpdt_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int ENTRIES_MAX = 256;
    localparam int IDX_W       = $clog2(ENTRIES_MAX);
    localparam int CNT_W       = $clog2(ENTRIES_MAX + 1);

    localparam logic [2:0] CMD_LOOKUP = 3'd0;
    localparam logic [2:0] CMD_BIND   = 3'd1;
    localparam logic [2:0] CMD_UNBIND = 3'd2;
    localparam logic [2:0] CMD_SET_MC = 3'd3;
    localparam logic [2:0] CMD_SET_BC = 3'd4;

    localparam logic [1:0] CAST_UNI   = 2'd0;
    localparam logic [1:0] CAST_MULTI = 2'd1;
    localparam logic [1:0] CAST_BCAST = 2'd2;
    localparam logic [1:0] CAST_BAD   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_IN_USE = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [2:0]       cmd;
        logic [15:0]      port;
        logic [7:0]       sock;
        logic [1:0]       cast;
        logic             en;
        logic             done;
        logic             hit;
        logic [7:0]       target;
        logic [IDX_W-1:0] idx;
        logic             conf;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] removed;
    } t_tok;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [15:0]      port;
        logic [7:0]       sock;
    } t_commit;

endpackage

### design/udp_port_demux_table.sv
// Each request walks a row of ENTRIES slot cells, one cell per cycle. Its response
// passes from the launch register through the cell row and the hold register to
// the output register; it waits in the hold register while the output register
// still holds an unread response. One request is in the row at a time, and the
// next is taken as soon as the response has moved to the output register, even
// while that response waits to be read. The table is empty after reset.
// Counters wrap at 2^32.
// Top level of the UDP port demux table. Depends on udpdt_pkg, udpdt_cell.
module udp_port_demux_table #(
    parameter int ENTRIES = udpdt_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // port_number[15:0], socket_id[23:16], cast_type[25:24], enable[26]
    input  logic [31:0] i_s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // status[1:0], target_socket[9:2], slot_index[13:10],
    // removed_count[18:14], event_count[50:19]
    output logic [55:0] o_m_axis_tdata
);
    import udpdt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  target;
        logic [3:0]  slot;
        logic [4:0]  removed;
        logic [31:0] event_cnt;
    } t_resp;

    t_state      r_state;
    t_tok        r_launch;
    t_tok        n_launch;
    t_resp       r_hold;
    logic        r_out_valid;
    logic [55:0] r_out_data;
    logic [31:0] r_deliv0;
    logic [31:0] r_deliv1;
    logic [31:0] r_deliv2;
    logic [31:0] r_drop;

    t_tok         w_tok [0:ENTRIES];
    logic [ENTRIES-1:0] w_tv;
    t_tok         w_exit;
    t_commit      w_commit;
    t_resp        w_resp;
    logic [31:0]  w_sel;
    logic [31:0]  w_inc;
    logic         w_accept;
    logic         w_load;

    assign w_tok[0] = r_launch;
    assign w_exit   = w_tok[ENTRIES];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load   = (r_state == S_HOLD) && (!r_out_valid || i_m_axis_tready);

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        udpdt_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .i_commit (w_commit),
            .o_tok    (w_tok[g+1])
        );
        assign w_tv[g] = w_tok[g+1].valid;
    end

    assign w_commit.we   = w_exit.valid && (w_exit.cmd == CMD_BIND) &&
                           !w_exit.conf && w_exit.free_found;
    assign w_commit.idx  = w_exit.free_idx;
    assign w_commit.port = w_exit.port;
    assign w_commit.sock = w_exit.sock;

    always_comb begin
        n_launch = '0;
        if (w_accept) begin
            n_launch.valid = 1'b1;
            n_launch.cmd   = i_s_axis_tuser;
            n_launch.port  = i_s_axis_tdata[15:0];
            n_launch.sock  = i_s_axis_tdata[23:16];
            n_launch.cast  = i_s_axis_tdata[25:24];
            n_launch.en    = i_s_axis_tdata[26];
        end
    end

    always_comb begin
        if (w_exit.hit) begin
            unique case (w_exit.cast)
                CAST_UNI:   w_sel = r_deliv0;
                CAST_MULTI: w_sel = r_deliv1;
                default:    w_sel = r_deliv2;
            endcase
        end else begin
            w_sel = r_drop;
        end
    end

    assign w_inc = w_sel + 32'd1;

    always_comb begin
        w_resp = '0;
        w_resp.status = ST_NONE;
        unique case (w_exit.cmd)
            CMD_LOOKUP: begin
                w_resp.event_cnt = w_inc;
                if (w_exit.hit) begin
                    w_resp.status = ST_OK;
                    w_resp.target = w_exit.target;
                    w_resp.slot   = w_exit.idx[3:0];
                end
            end
            CMD_BIND: begin
                if (w_exit.conf) begin
                    w_resp.status = ST_IN_USE;
                    w_resp.slot   = w_exit.idx[3:0];
                end else if (w_exit.free_found) begin
                    w_resp.status = ST_OK;
                    w_resp.slot   = w_exit.free_idx[3:0];
                end else begin
                    w_resp.status = ST_FULL;
                end
            end
            CMD_UNBIND: begin
                w_resp.status  = ST_OK;
                w_resp.removed = w_exit.removed[4:0];
            end
            CMD_SET_MC, CMD_SET_BC: begin
                if (w_exit.done) begin
                    w_resp.status = ST_OK;
                    w_resp.slot   = w_exit.idx[3:0];
                end
            end
            default: begin
                w_resp.status = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= '0;
            r_out_valid <= 1'b0;
            r_deliv0    <= '0;
            r_deliv1    <= '0;
            r_deliv2    <= '0;
            r_drop      <= '0;
        end else begin
            r_launch <= n_launch;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_exit.valid) begin
                        r_hold <= w_resp;
                        if (w_exit.cmd == CMD_LOOKUP) begin
                            if (!w_exit.hit) begin
                                r_drop <= w_inc;
                            end else if (w_exit.cast == CAST_UNI) begin
                                r_deliv0 <= w_inc;
                            end else if (w_exit.cast == CAST_MULTI) begin
                                r_deliv1 <= w_inc;
                            end else begin
                                r_deliv2 <= w_inc;
                            end
                        end
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_load) begin
                        r_out_data <= {5'd0, r_hold.event_cnt, r_hold.removed,
                                       r_hold.slot, r_hold.target, r_hold.status};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tv))
        else $error("more than one request in the cell row");

    a_exit_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> (r_state == S_WALK))
        else $error("request left the cell row outside the walk");

    a_idle_row_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (w_tv == '0) && !r_launch.valid)
        else $error("request taken while the row is busy");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit.we |-> !w_exit.conf && (w_exit.cmd == CMD_BIND))
        else $error("slot fill without a free bind");
`endif

endmodule

### design/udpdt_cell.sv
// One slot of the UDP port demux table: holds the slot and advances the
// request token by one cell per cycle.
// Depends on udpdt_pkg.
module udpdt_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  udpdt_pkg::t_tok    i_tok,
    input  udpdt_pkg::t_commit i_commit,
    output udpdt_pkg::t_tok    o_tok
);
    import udpdt_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic        r_valid;
    logic [15:0] r_port;
    logic [7:0]  r_sock;
    logic        r_mc;
    logic        r_bc;
    t_tok        r_tok;
    t_tok        n_tok;

    logic w_port_hit;
    logic w_sock_hit;
    logic w_accept;
    logic w_fill;

    assign w_port_hit = r_valid && (r_port == i_tok.port);
    assign w_sock_hit = r_valid && (r_sock == i_tok.sock);
    assign w_accept   = (i_tok.cast == CAST_UNI) ||
                        ((i_tok.cast == CAST_MULTI) && r_mc) ||
                        ((i_tok.cast == CAST_BCAST) && r_bc);
    assign w_fill     = i_commit.we && (i_commit.idx == MY_IDX);

    always_comb begin
        n_tok = i_tok;
        unique case (i_tok.cmd)
            CMD_LOOKUP: begin
                if (!i_tok.done && w_port_hit) begin
                    if (i_tok.cast == CAST_BAD) begin
                        n_tok.done = 1'b1;
                    end else if (w_accept) begin
                        n_tok.done   = 1'b1;
                        n_tok.hit    = 1'b1;
                        n_tok.target = r_sock;
                        n_tok.idx    = MY_IDX;
                    end
                end
            end
            CMD_BIND: begin
                if (w_port_hit && !i_tok.conf) begin
                    n_tok.conf = 1'b1;
                    n_tok.idx  = MY_IDX;
                end
                if (!r_valid && !i_tok.free_found) begin
                    n_tok.free_found = 1'b1;
                    n_tok.free_idx   = MY_IDX;
                end
            end
            CMD_UNBIND: begin
                if (w_sock_hit) begin
                    n_tok.removed = i_tok.removed + CNT_W'(1);
                end
            end
            CMD_SET_MC, CMD_SET_BC: begin
                if (!i_tok.done && w_sock_hit) begin
                    n_tok.done = 1'b1;
                    n_tok.idx  = MY_IDX;
                end
            end
            default: begin
                n_tok = i_tok;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (w_fill) begin
                r_valid <= 1'b1;
            end else if (i_tok.valid && (i_tok.cmd == CMD_UNBIND) && w_sock_hit) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fill) begin
            r_port <= i_commit.port;
            r_sock <= i_commit.sock;
            r_mc   <= 1'b0;
            r_bc   <= 1'b0;
        end else if (i_tok.valid && !i_tok.done && w_sock_hit) begin
            if (i_tok.cmd == CMD_SET_MC) begin
                r_mc <= i_tok.en;
            end else if (i_tok.cmd == CMD_SET_BC) begin
                r_bc <= i_tok.en;
            end
        end
    end

    assign o_tok = r_tok;

endmodule
